[src/refcounted_page_allocator_macros.svh]
// assertion macros for the reference counted page allocator
`ifndef REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define RPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPA_ASSERT_SAME(label, ante, cons, msg)
`define RPA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[src/rpa_pkg.sv]
// shared types and constants of the reference counted page allocator
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int NUM_PAGES = 32768;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int TOP_W     = PAGE_W + 1;
  localparam int FRAME_W   = 52;
  localparam int CNT_W     = 8;
  localparam int FREE_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int KIND_W    = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_EMPTY    = 3'd1,
    STATUS_RANGE    = 3'd2,
    STATUS_SHARED   = 3'd3,
    STATUS_DOUBLE   = 3'd4,
    STATUS_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_ADDREF = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

endpackage

[src/refcounted_page_allocator.sv]
// Reference counted page allocator: the block keeps a stack of free pages
// and an 8-bit reference count per page, in two on-chip memories.
// Input channel in_valid/in_stall carries one request (in_kind, in_page_frame):
// allocate, free, or add reference. Each request gives exactly one result on
// out_valid/out_stall: status, frame, count after the request and free pages.
// cfg_valid/cfg_ready writes base_page, the frame number of page 0; write it
// only while no request is in flight.
// After acceptance the shared 52-bit adder forms frame minus base in the
// accepting cycle; a memory read state and an update state follow, and the
// update state also forms the allocated frame on the adder.
// in_stall is high from acceptance until the result has entered the output
// register, so no new request is accepted before then.
// A stalled result holds in the output register; the update cycle waits until
// the register is free, and no new request is taken while it waits.
// After reset a clearing pass zeroes every entry of the count memory, one entry
// a cycle; in_stall stays high meanwhile and configuration is accepted.
// All pages start free, page 32767 on top of the stack.
`timescale 1ns / 1ps
`include "refcounted_page_allocator_macros.svh"

module refcounted_page_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpa_pkg::FRAME_W-1:0]   cfg_base_page,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpa_pkg::KIND_W-1:0]    in_kind,
  input  logic [rpa_pkg::FRAME_W-1:0]   in_page_frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpa_pkg::STATUS_W-1:0]  out_status,
  output logic [rpa_pkg::FRAME_W-1:0]   out_result_frame,
  output logic [rpa_pkg::CNT_W-1:0]     out_ref_count,
  output logic [rpa_pkg::FREE_W-1:0]    out_free_pages
);

  localparam int PW = rpa_pkg::PAGE_W;
  localparam int TW = rpa_pkg::TOP_W;
  localparam int FW = rpa_pkg::FRAME_W;
  localparam int CW = rpa_pkg::CNT_W;
  localparam logic [TW-1:0] TOP_FULL = TW'(rpa_pkg::NUM_PAGES);

  rpa_pkg::state_t state_r, state_nxt;

  logic [FW-1:0] base_page_r;
  logic [TW-1:0] stack_top_r, stack_top_nxt;
  logic [TW-1:0] low_water_r, low_water_nxt;
  logic [PW-1:0] clr_addr_r;
  logic [rpa_pkg::KIND_W-1:0] kind_r;
  logic [FW-1:0] frame_r;
  logic [FW-1:0] idx_r;

  logic [PW-1:0] stk_mem [rpa_pkg::NUM_PAGES];
  logic [CW-1:0] cnt_mem [rpa_pkg::NUM_PAGES];
  logic [PW-1:0] stk_rd_r;
  logic [CW-1:0] cnt_rd_r;

  logic                out_valid_r;
  rpa_pkg::status_t    out_status_r, status_nxt;
  logic [FW-1:0]       out_frame_r, frame_nxt;
  logic [CW-1:0]       out_count_r, count_nxt;
  logic [rpa_pkg::FREE_W-1:0] out_free_r;

  // shared adder
  logic [FW-1:0] add_a, add_b, add_sum;
  logic          add_cin;

  logic          in_accept, exec_go, out_load;
  logic [TW-1:0] pop_addr;
  logic [PW-1:0] stk_val;
  logic          in_range;

  logic          cnt_we, stk_we;
  logic [PW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != rpa_pkg::ST_IDLE);
  assign cfg_ready = state_r inside {rpa_pkg::ST_CLEAR, rpa_pkg::ST_IDLE};
  assign out_load  = !out_valid_r || !out_stall;
  assign exec_go   = (state_r == rpa_pkg::ST_EXEC) && out_load;

  assign pop_addr = stack_top_r - TW'(1);
  assign stk_val  = (stack_top_r <= low_water_r) ? pop_addr[PW-1:0] : stk_rd_r;
  assign in_range = (idx_r[FW-1:PW] == '0);

  always_comb begin
    if (state_r == rpa_pkg::ST_EXEC) begin
      add_a   = base_page_r;
      add_b   = {{(FW-PW){1'b0}}, stk_val};
      add_cin = 1'b0;
    end else begin
      add_a   = in_page_frame;
      add_b   = ~base_page_r;
      add_cin = 1'b1;
    end
  end

  assign add_sum = add_a + add_b + {{(FW-1){1'b0}}, add_cin};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpa_pkg::ST_CLEAR: begin
        if (clr_addr_r == {PW{1'b1}}) state_nxt = rpa_pkg::ST_IDLE;
      end
      rpa_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = rpa_pkg::ST_READ;
      end
      rpa_pkg::ST_READ: begin
        state_nxt = rpa_pkg::ST_EXEC;
      end
      rpa_pkg::ST_EXEC: begin
        if (exec_go) state_nxt = rpa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    status_nxt    = rpa_pkg::STATUS_OK;
    frame_nxt     = frame_r;
    count_nxt     = '0;
    stack_top_nxt = stack_top_r;
    low_water_nxt = low_water_r;
    cnt_we        = 1'b0;
    cnt_waddr     = idx_r[PW-1:0];
    cnt_wdata     = '0;
    stk_we        = 1'b0;
    case (kind_r)
      rpa_pkg::KIND_ALLOC: begin
        if (stack_top_r == '0) begin
          status_nxt = rpa_pkg::STATUS_EMPTY;
          frame_nxt  = '0;
        end else begin
          frame_nxt     = add_sum;
          count_nxt     = CW'(1);
          stack_top_nxt = pop_addr;
          if (pop_addr < low_water_r) low_water_nxt = pop_addr;
          cnt_we        = 1'b1;
          cnt_waddr     = stk_val;
          cnt_wdata     = CW'(1);
        end
      end
      rpa_pkg::KIND_FREE: begin
        if (!in_range) begin
          status_nxt = rpa_pkg::STATUS_RANGE;
        end else if (cnt_rd_r == '0) begin
          status_nxt = rpa_pkg::STATUS_DOUBLE;
        end else if (cnt_rd_r != CW'(1)) begin
          status_nxt = rpa_pkg::STATUS_SHARED;
          count_nxt  = cnt_rd_r - CW'(1);
          cnt_we     = 1'b1;
          cnt_wdata  = cnt_rd_r - CW'(1);
        end else begin
          cnt_we = 1'b1;
          if (stack_top_r < TOP_FULL) begin
            stk_we        = 1'b1;
            stack_top_nxt = stack_top_r + TW'(1);
          end
        end
      end
      rpa_pkg::KIND_ADDREF: begin
        if (!in_range) begin
          status_nxt = rpa_pkg::STATUS_RANGE;
        end else if (cnt_rd_r == rpa_pkg::CNT_MAX) begin
          status_nxt = rpa_pkg::STATUS_OVERFLOW;
          count_nxt  = rpa_pkg::CNT_MAX;
        end else begin
          count_nxt = cnt_rd_r + CW'(1);
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd_r + CW'(1);
        end
      end
      default: begin
        frame_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpa_pkg::ST_CLEAR;
      base_page_r <= '0;
      stack_top_r <= TOP_FULL;
      low_water_r <= TOP_FULL;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) base_page_r <= cfg_base_page;
      if (state_r == rpa_pkg::ST_CLEAR) clr_addr_r <= clr_addr_r + PW'(1);
      if (exec_go) begin
        stack_top_r <= stack_top_nxt;
        low_water_r <= low_water_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r  <= in_kind;
      frame_r <= in_page_frame;
      idx_r   <= add_sum;
    end
    if (exec_go) begin
      out_status_r <= status_nxt;
      out_frame_r  <= frame_nxt;
      out_count_r  <= count_nxt;
      out_free_r   <= rpa_pkg::FREE_W'(stack_top_nxt);
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (state_r == rpa_pkg::ST_CLEAR) begin
      cnt_mem[clr_addr_r] <= '0;
    end else if (exec_go && cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (state_r == rpa_pkg::ST_READ) cnt_rd_r <= cnt_mem[idx_r[PW-1:0]];
  end

  // free stack memory, entries below the low water mark read as their index
  always_ff @(posedge clk) begin
    if (exec_go && stk_we) stk_mem[stack_top_r[PW-1:0]] <= idx_r[PW-1:0];
    if (state_r == rpa_pkg::ST_READ) stk_rd_r <= stk_mem[pop_addr[PW-1:0]];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_frame = out_frame_r;
  assign out_ref_count    = out_count_r;
  assign out_free_pages   = out_free_r;

  `RPA_ASSERT_SAME(a_low_water, 1'b1, (low_water_r <= stack_top_r) && (stack_top_r <= TOP_FULL), "stack top below low water mark or above capacity")
  `RPA_ASSERT_SAME(a_result_src, $rose(out_valid_r), $past(state_r) == rpa_pkg::ST_EXEC, "result appeared outside the update cycle")
  `RPA_ASSERT_SAME(a_empty_free, out_valid_r && (out_status_r == rpa_pkg::STATUS_EMPTY), out_free_r == '0, "out of pages reported with free pages left")
  `RPA_ASSERT_NEXT(a_accept_read, in_accept, (state_r == rpa_pkg::ST_READ) && in_stall, "accepted transaction did not start a memory read")

endmodule
